>>> hdl/bfvd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfvd_pkg: shared types and constants of the box filter volume downsampler
// Register indexes, controller states, command/status groups and fixed widths.
// ----------------------------------------------------------------------------
package bfvd_pkg;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 10;
    localparam int SRC_REG_W  = 10;
    localparam int DST_REG_W  = 9;

    localparam logic [SRC_REG_W-1:0] SRC_RESET = 10'd512;
    localparam logic [DST_REG_W-1:0] DST_RESET = 9'd256;

    // accumulator and result widths
    localparam int ACC_W  = 48;
    localparam int QUOT_W = ACC_W - 1;
    localparam int IDX_W  = 24;

    // accumulator saturation limits, +-(2^47 - 1)
    localparam logic signed [ACC_W:0] SUM_LIMIT = {2'b00, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W:0] SUM_FLOOR = -SUM_LIMIT;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SRC_X = 3'd0,
        REG_SRC_Y = 3'd1,
        REG_SRC_Z = 3'd2,
        REG_DST_X = 3'd3,
        REG_DST_Y = 3'd4,
        REG_DST_Z = 3'd5
    } reg_index_t;

    typedef enum logic [1:0] {
        DSRC_X   = 2'd0,
        DSRC_Y   = 2'd1,
        DSRC_Z   = 2'd2,
        DSRC_AVG = 2'd3
    } div_src_t;

    typedef enum logic [3:0] {
        ST_FX_GO    = 4'd0,
        ST_FX_WAIT  = 4'd1,
        ST_FY_GO    = 4'd2,
        ST_FY_WAIT  = 4'd3,
        ST_FZ_GO    = 4'd4,
        ST_FZ_WAIT  = 4'd5,
        ST_MUL1     = 4'd6,
        ST_MUL2     = 4'd7,
        ST_IDLE     = 4'd8,
        ST_UPDATE   = 4'd9,
        ST_DIV_WAIT = 4'd10,
        ST_EMIT     = 4'd11
    } state_t;

    typedef struct packed {
        logic     div_start;
        div_src_t div_src;
        logic     load_factor;
        logic     mul_a;
        logic     mul_b;
        logic     accept;
        logic     update;
        logic     load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic cfg_hit;
        logic div_done;
        logic emit;
        logic out_free;
    } ctrl_status_t;

endpackage : bfvd_pkg
`default_nettype wire

>>> hdl/bfvd_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfvd_divider: unsigned restoring divider, one quotient bit per cycle
// Loads on start, pulses done when the quotient is complete and holds it.
// ----------------------------------------------------------------------------
module bfvd_divider
    import bfvd_pkg::*;
#(
    parameter int DVS_W = 30
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [QUOT_W-1:0] dividend,
    input  wire logic [DVS_W-1:0]  divisor,
    output logic      [QUOT_W-1:0] quotient,
    output logic                   done
);

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVS_W-1:0]  dvs_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DVS_W:0] shifted;
    logic [DVS_W:0] diff;
    logic           fits;

    always_comb
    begin
        shifted   = {rem_reg, quot_reg[QUOT_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        fits      = (shifted >= {1'b0, dvs_reg});
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(QUOT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[QUOT_W-2:0], fits};
            rem_next  = fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign quotient = quot_reg;
    assign done     = done_reg;

endmodule : bfvd_divider
`default_nettype wire

>>> hdl/bfvd_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfvd_datapath: config registers, block counters, slab memory and divider
// Accumulates voxels into per-target sums and forms the block average.
// ----------------------------------------------------------------------------
module bfvd_datapath
    import bfvd_pkg::*;
#(
    parameter int MAX_SRC_SIZE = 512,
    parameter int MAX_DST_SIZE = 256,
    parameter int SAMPLE_BITS  = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wr_data,
    input  wire logic [SAMPLE_BITS-1:0] voxel_value,
    input  wire logic                   out_ready,
    input  wire ctrl_cmd_t              cmd,
    output ctrl_status_t                status,
    output logic                        out_valid,
    output logic [SAMPLE_BITS-1:0]      average_value,
    output logic [IDX_W-1:0]            target_index,
    output logic                        volume_done
);

    localparam int SRC_W      = $clog2(MAX_SRC_SIZE + 1);
    localparam int DST_W      = $clog2(MAX_DST_SIZE + 1);
    localparam int POS_W      = $clog2(MAX_SRC_SIZE);
    localparam int FACTOR_W   = SRC_W;
    localparam int DVS_W      = 3 * FACTOR_W;
    localparam int SLAB_DEPTH = MAX_DST_SIZE * MAX_DST_SIZE;
    localparam int SLOT_W     = (SLAB_DEPTH > 1) ? $clog2(SLAB_DEPTH) : 1;
    localparam int SRC_CW     = (SRC_W > SRC_REG_W) ? SRC_W : SRC_REG_W;
    localparam int DST_CW     = (DST_W > DST_REG_W) ? DST_W : DST_REG_W;

    function automatic logic [SRC_W-1:0] eff_src(input logic [SRC_REG_W-1:0] v);
        logic [SRC_W-1:0] r;
        if (v == '0)
            r = SRC_W'(1);
        else if (SRC_CW'(v) > SRC_CW'(MAX_SRC_SIZE))
            r = SRC_W'(MAX_SRC_SIZE);
        else
            r = SRC_W'(v);
        return r;
    endfunction

    function automatic logic [DST_W-1:0] eff_dst(input logic [DST_REG_W-1:0] v);
        logic [DST_W-1:0] r;
        if (v == '0)
            r = DST_W'(1);
        else if (DST_CW'(v) > DST_CW'(MAX_DST_SIZE))
            r = DST_W'(MAX_DST_SIZE);
        else
            r = DST_W'(v);
        return r;
    endfunction

    // configuration registers
    logic [SRC_REG_W-1:0] src_x_reg, src_y_reg, src_z_reg;
    logic [DST_REG_W-1:0] dst_x_reg, dst_y_reg, dst_z_reg;
    logic                 cfg_hit;

    always_comb
    begin
        cfg_hit = 1'b0;
        unique case (reg_index_t'(cfg_addr))
            REG_SRC_X, REG_SRC_Y, REG_SRC_Z,
            REG_DST_X, REG_DST_Y, REG_DST_Z: cfg_hit = cfg_wr_en;
            default:                         cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_x_reg <= SRC_RESET;
            src_y_reg <= SRC_RESET;
            src_z_reg <= SRC_RESET;
            dst_x_reg <= DST_RESET;
            dst_y_reg <= DST_RESET;
            dst_z_reg <= DST_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (reg_index_t'(cfg_addr))
                REG_SRC_X: src_x_reg <= cfg_wr_data[SRC_REG_W-1:0];
                REG_SRC_Y: src_y_reg <= cfg_wr_data[SRC_REG_W-1:0];
                REG_SRC_Z: src_z_reg <= cfg_wr_data[SRC_REG_W-1:0];
                REG_DST_X: dst_x_reg <= cfg_wr_data[DST_REG_W-1:0];
                REG_DST_Y: dst_y_reg <= cfg_wr_data[DST_REG_W-1:0];
                REG_DST_Z: dst_z_reg <= cfg_wr_data[DST_REG_W-1:0];
                default:   ;
            endcase
        end
    end

    logic [SRC_W-1:0] sx_eff, sy_eff, sz_eff;
    logic [DST_W-1:0] dx_eff, dy_eff, dz_eff;

    assign sx_eff = eff_src(src_x_reg);
    assign sy_eff = eff_src(src_y_reg);
    assign sz_eff = eff_src(src_z_reg);
    assign dx_eff = eff_dst(dst_x_reg);
    assign dy_eff = eff_dst(dst_y_reg);
    assign dz_eff = eff_dst(dst_z_reg);

    // derived factors and products
    logic [FACTOR_W-1:0]   fx_reg, fy_reg, fz_reg;
    logic [2*FACTOR_W-1:0] fxy_reg;
    logic [DVS_W-1:0]      divisor_reg;
    logic [2*DST_W-1:0]    dxdy_reg;

    // divider operands
    logic [QUOT_W-1:0] div_dividend;
    logic [DVS_W-1:0]  div_divisor;
    logic [QUOT_W-1:0] div_quot;
    logic              div_done;
    logic [QUOT_W-1:0] acc_mag;

    always_comb
    begin
        case (cmd.div_src)
            DSRC_X:
            begin
                div_dividend = QUOT_W'(sx_eff) + QUOT_W'(dx_eff) - QUOT_W'(1);
                div_divisor  = DVS_W'(dx_eff);
            end
            DSRC_Y:
            begin
                div_dividend = QUOT_W'(sy_eff) + QUOT_W'(dy_eff) - QUOT_W'(1);
                div_divisor  = DVS_W'(dy_eff);
            end
            DSRC_Z:
            begin
                div_dividend = QUOT_W'(sz_eff) + QUOT_W'(dz_eff) - QUOT_W'(1);
                div_divisor  = DVS_W'(dz_eff);
            end
            default:
            begin
                div_dividend = acc_mag;
                div_divisor  = divisor_reg;
            end
        endcase
    end

    bfvd_divider #(
        .DVS_W    (DVS_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .done     (div_done)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_factor)
        begin
            case (cmd.div_src)
                DSRC_X:  fx_reg <= div_quot[FACTOR_W-1:0];
                DSRC_Y:  fy_reg <= div_quot[FACTOR_W-1:0];
                DSRC_Z:  fz_reg <= div_quot[FACTOR_W-1:0];
                default: ;
            endcase
        end
        if (cmd.mul_a)
        begin
            fxy_reg  <= fx_reg * fy_reg;
            dxdy_reg <= dx_eff * dy_eff;
        end
        if (cmd.mul_b)
        begin
            divisor_reg <= fxy_reg * fz_reg;
        end
    end

    // source position and block counters
    logic [POS_W-1:0]  pos_x_reg, pos_x_next, pos_y_reg, pos_y_next, pos_z_reg, pos_z_next;
    logic [POS_W-1:0]  sub_x_reg, sub_x_next, sub_y_reg, sub_y_next, sub_z_reg, sub_z_next;
    logic [DST_W-1:0]  tx_reg, tx_next;
    logic [SLOT_W-1:0] row_base_reg, row_base_next;
    logic [IDX_W-1:0]  slab_base_reg, slab_base_next;

    logic [SRC_W-1:0]  pos_x_inc, pos_y_inc, pos_z_inc;
    logic [SRC_W-1:0]  sub_x_inc, sub_y_inc, sub_z_inc;
    logic              end_x, end_y, end_z;
    logic              wrap_x, wrap_y, wrap_z;
    logic              emit, first_blk;
    logic [SLOT_W-1:0] slot;

    always_comb
    begin
        pos_x_inc = SRC_W'(pos_x_reg) + SRC_W'(1);
        pos_y_inc = SRC_W'(pos_y_reg) + SRC_W'(1);
        pos_z_inc = SRC_W'(pos_z_reg) + SRC_W'(1);
        sub_x_inc = SRC_W'(sub_x_reg) + SRC_W'(1);
        sub_y_inc = SRC_W'(sub_y_reg) + SRC_W'(1);
        sub_z_inc = SRC_W'(sub_z_reg) + SRC_W'(1);
        end_x     = (pos_x_inc >= sx_eff);
        end_y     = (pos_y_inc >= sy_eff);
        end_z     = (pos_z_inc >= sz_eff);
        wrap_x    = (sub_x_inc == fx_reg);
        wrap_y    = (sub_y_inc == fy_reg);
        wrap_z    = (sub_z_inc == fz_reg);
        emit      = (wrap_x || end_x) && (wrap_y || end_y) && (wrap_z || end_z);
        // first voxel of a block: the stale slab entry is taken as zero
        first_blk = (sub_x_reg == '0) && (sub_y_reg == '0) && (sub_z_reg == '0);
        slot      = row_base_reg + SLOT_W'(tx_reg);
    end

    always_comb
    begin
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        pos_z_next     = pos_z_reg;
        sub_x_next     = sub_x_reg;
        sub_y_next     = sub_y_reg;
        sub_z_next     = sub_z_reg;
        tx_next        = tx_reg;
        row_base_next  = row_base_reg;
        slab_base_next = slab_base_reg;
        if (cfg_hit)
        begin
            pos_x_next     = '0;
            pos_y_next     = '0;
            pos_z_next     = '0;
            sub_x_next     = '0;
            sub_y_next     = '0;
            sub_z_next     = '0;
            tx_next        = '0;
            row_base_next  = '0;
            slab_base_next = '0;
        end
        else if (cmd.update)
        begin
            if (end_x)
            begin
                pos_x_next = '0;
                sub_x_next = '0;
                tx_next    = '0;
            end
            else
            begin
                pos_x_next = POS_W'(pos_x_inc);
                if (wrap_x)
                begin
                    sub_x_next = '0;
                    tx_next    = tx_reg + DST_W'(1);
                end
                else
                begin
                    sub_x_next = POS_W'(sub_x_inc);
                end
            end
            if (end_x)
            begin
                if (end_y)
                begin
                    pos_y_next    = '0;
                    sub_y_next    = '0;
                    row_base_next = '0;
                end
                else
                begin
                    pos_y_next = POS_W'(pos_y_inc);
                    if (wrap_y)
                    begin
                        sub_y_next    = '0;
                        row_base_next = row_base_reg + SLOT_W'(dx_eff);
                    end
                    else
                    begin
                        sub_y_next = POS_W'(sub_y_inc);
                    end
                end
            end
            if (end_x && end_y)
            begin
                if (end_z)
                begin
                    pos_z_next     = '0;
                    sub_z_next     = '0;
                    slab_base_next = '0;
                end
                else
                begin
                    pos_z_next = POS_W'(pos_z_inc);
                    if (wrap_z)
                    begin
                        sub_z_next     = '0;
                        slab_base_next = slab_base_reg + IDX_W'(dxdy_reg);
                    end
                    else
                    begin
                        sub_z_next = POS_W'(sub_z_inc);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            pos_z_reg     <= '0;
            sub_x_reg     <= '0;
            sub_y_reg     <= '0;
            sub_z_reg     <= '0;
            tx_reg        <= '0;
            row_base_reg  <= '0;
            slab_base_reg <= '0;
        end
        else
        begin
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            pos_z_reg     <= pos_z_next;
            sub_x_reg     <= sub_x_next;
            sub_y_reg     <= sub_y_next;
            sub_z_reg     <= sub_z_next;
            tx_reg        <= tx_next;
            row_base_reg  <= row_base_next;
            slab_base_reg <= slab_base_next;
        end
    end

    // slab accumulator memory, read on accept, written back on update
    logic [ACC_W-1:0]       slab_mem [SLAB_DEPTH];
    logic [ACC_W-1:0]       rd_data_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;

    logic signed [ACC_W:0] sum_wide;
    logic [ACC_W-1:0]      acc_base;
    logic [ACC_W-1:0]      acc_sat;
    logic [ACC_W-1:0]      acc_negated;
    logic [ACC_W-1:0]      wr_data;

    always_comb
    begin
        acc_base = first_blk ? '0 : rd_data_reg;
        sum_wide = $signed({acc_base[ACC_W-1], acc_base})
                 + $signed({{(ACC_W+1-SAMPLE_BITS){sample_reg[SAMPLE_BITS-1]}}, sample_reg});
        if (sum_wide > SUM_LIMIT)
            acc_sat = SUM_LIMIT[ACC_W-1:0];
        else if (sum_wide < SUM_FLOOR)
            acc_sat = SUM_FLOOR[ACC_W-1:0];
        else
            acc_sat = sum_wide[ACC_W-1:0];
        acc_negated = -acc_sat;
        acc_mag     = acc_sat[ACC_W-1] ? acc_negated[QUOT_W-1:0] : acc_sat[QUOT_W-1:0];
        wr_data     = emit ? '0 : acc_sat;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rd_data_reg <= slab_mem[slot];
            sample_reg  <= voxel_value;
        end
        if (cmd.update)
        begin
            slab_mem[slot] <= wr_data;
        end
    end

    // result held while the divide runs, then moved to the output register
    logic [IDX_W-1:0]       idx_hold_reg;
    logic                   done_hold_reg;
    logic                   neg_reg;
    logic [QUOT_W-1:0]      quot_signed;
    logic [SAMPLE_BITS-1:0] out_avg_reg;
    logic [IDX_W-1:0]       out_idx_reg;
    logic                   out_done_reg;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_free;

    always_ff @(posedge clk)
    begin
        if (cmd.update && emit)
        begin
            idx_hold_reg  <= slab_base_reg + IDX_W'(slot);
            done_hold_reg <= end_x && end_y && end_z;
            neg_reg       <= acc_sat[ACC_W-1];
        end
        if (cmd.load_out)
        begin
            out_avg_reg  <= quot_signed[SAMPLE_BITS-1:0];
            out_idx_reg  <= idx_hold_reg;
            out_done_reg <= done_hold_reg;
        end
    end

    assign quot_signed = neg_reg ? (~div_quot + QUOT_W'(1)) : div_quot;
    assign out_free    = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign status.cfg_hit  = cfg_hit;
    assign status.div_done = div_done;
    assign status.emit     = emit;
    assign status.out_free = out_free;

    assign out_valid     = out_valid_reg;
    assign average_value = out_avg_reg;
    assign target_index  = out_idx_reg;
    assign volume_done   = out_done_reg;

`ifndef SYNTHESIS
    a_tx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> (tx_reg < dx_eff))
        else $error("target x counter beyond target width");

    a_sub_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> ((SRC_W'(sub_x_reg) < fx_reg) && (SRC_W'(sub_y_reg) < fy_reg)
                        && (SRC_W'(sub_z_reg) < fz_reg)))
        else $error("block sub-position reached its factor");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> out_free)
        else $error("output register overwritten while a result waits");
`endif

endmodule : bfvd_datapath
`default_nettype wire

>>> hdl/bfvd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfvd_ctrl: sequencer of the downsampler
// Derives factors after reset or a register write, then steps one voxel
// through read, update and, when a block closes, divide and emit.
// ----------------------------------------------------------------------------
module bfvd_ctrl
    import bfvd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire ctrl_status_t status,
    output ctrl_cmd_t         cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_FX_GO;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_FX_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_src   = DSRC_X;
                state_next    = ST_FX_WAIT;
            end
            ST_FX_WAIT:
            begin
                cmd.div_src = DSRC_X;
                if (status.div_done)
                begin
                    cmd.load_factor = 1'b1;
                    state_next      = ST_FY_GO;
                end
            end
            ST_FY_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_src   = DSRC_Y;
                state_next    = ST_FY_WAIT;
            end
            ST_FY_WAIT:
            begin
                cmd.div_src = DSRC_Y;
                if (status.div_done)
                begin
                    cmd.load_factor = 1'b1;
                    state_next      = ST_FZ_GO;
                end
            end
            ST_FZ_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_src   = DSRC_Z;
                state_next    = ST_FZ_WAIT;
            end
            ST_FZ_WAIT:
            begin
                cmd.div_src = DSRC_Z;
                if (status.div_done)
                begin
                    cmd.load_factor = 1'b1;
                    state_next      = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                cmd.mul_a  = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul_b  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update  = 1'b1;
                cmd.div_src = DSRC_AVG;
                if (status.emit)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV_WAIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV_WAIT:
            begin
                cmd.div_src = DSRC_AVG;
                if (status.div_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.div_src = DSRC_AVG;
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_FX_GO;
            end
        endcase
        // any register write restarts the volume and re-derives the factors
        if (status.cfg_hit)
            state_next = ST_FX_GO;
    end

endmodule : bfvd_ctrl
`default_nettype wire

>>> hdl/box_filter_volume_downsample_core.sv
`default_nettype none
// a voxel that closes no block steps through accept and slab update
// a voxel that closes a block steps through accept, slab update, a divide on the
//   shared divider, one quotient bit per cycle (47 steps), and the output register load
// a new voxel is taken only once the last one is updated or, if it closed a block, its result loaded
// reset and any register write: factor derivation on the same divider
//   with s_axis_tready low; slab memory needs no clearing pass
// ----------------------------------------------------------------------------
// box_filter_volume_downsample_core: 3D box filter downsampler
// Sums raster-ordered voxels per target block and emits the truncated average.
// ----------------------------------------------------------------------------
module box_filter_volume_downsample_core
    import bfvd_pkg::*;
#(
    parameter int MAX_SRC_SIZE = 512,
    parameter int MAX_DST_SIZE = 256,
    parameter int SAMPLE_BITS  = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // configuration write port
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,

    // voxel stream in
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // voxel_value
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,

    // averaged target stream out
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // average_value, target_index
    output logic [((SAMPLE_BITS+IDX_W+7)/8)*8-1:0] m_axis_tdata,
    // volume_done
    output logic [0:0]                 m_axis_tuser
);

    localparam int OUT_W = ((SAMPLE_BITS + IDX_W + 7) / 8) * 8;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    logic [SAMPLE_BITS-1:0] average_value;
    logic [IDX_W-1:0]       target_index;
    logic                   volume_done;

    // sequencer: factor derivation after reset or a write, then per-voxel steps
    bfvd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // counters, slab memory, accumulate/saturate, divider and output register;
    // the output register lets the next voxel be taken while a result waits
    bfvd_datapath #(
        .MAX_SRC_SIZE  (MAX_SRC_SIZE),
        .MAX_DST_SIZE  (MAX_DST_SIZE),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data),
        .voxel_value   (s_axis_tdata[SAMPLE_BITS-1:0]),
        .out_ready     (m_axis_tready),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (m_axis_tvalid),
        .average_value (average_value),
        .target_index  (target_index),
        .volume_done   (volume_done)
    );

    // pack the result request: average in the low bits, then the target index
    assign m_axis_tdata = OUT_W'({target_index, average_value});
    assign m_axis_tuser = volume_done;

endmodule : box_filter_volume_downsample_core
`default_nettype wire
